// ----- rtl/cobs_dec_pkg.sv -----
`default_nettype none

package cobs_dec_pkg;

  localparam int MAX_FRAME = 2048;
  localparam int COUNT_W   = $clog2(MAX_FRAME);
  localparam int LEN_W     = 11;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_FRAME - 1);

  localparam logic [7:0] CODE_FULL = 8'hFF;
  localparam logic [7:0] DELIM     = 8'h00;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_END      = 3'd1,
    KIND_EMPTY    = 3'd2,
    KIND_GARBAGE  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/cobs_dec_rx_if.sv -----
`default_nettype none

interface cobs_dec_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/cobs_dec_res_if.sv -----
`default_nettype none

interface cobs_dec_res_if;
  import cobs_dec_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_length, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/cobs_dec_core.sv -----
`default_nettype none

module cobs_dec_core
  import cobs_dec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  input  wire logic       res_ready,
  output result_t         res
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // decoder state
  logic [7:0]         current_code;
  logic [7:0]         block_remaining;
  logic [COUNT_W-1:0] written_count;

  logic [7:0]         current_code_next;
  logic [7:0]         block_remaining_next;
  logic [COUNT_W-1:0] written_count_next;

  logic has_result;
  logic take;
  logic at_limit;
  logic is_delim;

  assign at_limit = (written_count == COUNT_LIMIT);
  assign is_delim = (s1_byte == DELIM);

  always_comb begin
    current_code_next    = current_code;
    block_remaining_next = block_remaining;
    written_count_next   = written_count;
    has_result           = 1'b1;
    res.kind             = KIND_DATA;
    res.data_byte        = 8'h00;
    res.frame_length     = '0;

    if (at_limit && !is_delim) begin
      // overflow: abort, then this byte opens a new frame as its code byte
      res.kind             = KIND_OVERFLOW;
      current_code_next    = s1_byte;
      block_remaining_next = s1_byte - 8'd1;
      written_count_next   = '0;
    end else if (block_remaining != 8'h00) begin
      if (is_delim) begin
        res.kind             = KIND_GARBAGE;
        current_code_next    = CODE_FULL;
        block_remaining_next = 8'h00;
        written_count_next   = '0;
      end else begin
        res.data_byte        = s1_byte;
        block_remaining_next = block_remaining - 8'd1;
        written_count_next   = written_count + COUNT_W'(1);
      end
    end else if (is_delim) begin
      if (current_code == CODE_FULL && written_count == '0) begin
        res.kind = KIND_EMPTY;
      end else begin
        res.kind         = KIND_END;
        res.frame_length = LEN_W'(written_count);
      end
      current_code_next    = CODE_FULL;
      block_remaining_next = 8'h00;
      written_count_next   = '0;
    end else begin
      current_code_next    = s1_byte;
      block_remaining_next = s1_byte - 8'd1;
      if (current_code != CODE_FULL) begin
        // restored zero at the block boundary
        written_count_next = written_count + COUNT_W'(1);
      end else begin
        has_result = 1'b0;
      end
    end
  end

  assign take      = s1_valid && (!has_result || res_ready);
  assign res_valid = s1_valid && has_result;
  assign rx_ready  = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ready) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_code    <= CODE_FULL;
      block_remaining <= 8'h00;
      written_count   <= '0;
    end else if (take) begin
      current_code    <= current_code_next;
      block_remaining <= block_remaining_next;
      written_count   <= written_count_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    written_count <= COUNT_LIMIT)
    else $error("frame byte count past its limit");

  a_block_in_code : assert property (@(posedge clk) disable iff (rst)
    block_remaining < current_code)
    else $error("bytes left in block not below code byte");

  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    take && res_valid && (res.kind == KIND_END || res.kind == KIND_EMPTY ||
      res.kind == KIND_GARBAGE)
    |=> current_code == CODE_FULL && block_remaining == 8'h00 && written_count == '0)
    else $error("frame state not restarted after frame close");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !take |=> s1_valid && $stable(s1_byte) && $stable(written_count))
    else $error("stalled byte or state changed");

endmodule

`default_nettype wire

// ----- rtl/cobs_dec_out_reg.sv -----
`default_nettype none

module cobs_dec_out_reg
  import cobs_dec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_res,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid;
  result_t res;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= in_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cobs_stream_decoder.sv -----
// channel | dir | payload                                    | handshake
// rx      | in  | rx_byte[7:0]                               | valid/ready
// res     | out | kind[2:0], data_byte[7:0], frame_length[10:0] | valid/ready
//
// one byte per cycle unless res stalls; each byte gives at most one result
// datapath: byte register, decode logic, result register driving res.valid
// rst (synchronous) empties both registers and restarts the frame state
// a stall on res backs up through the result register into the byte register;
// a code byte with no result never waits on res
`default_nettype none

module cobs_stream_decoder
  import cobs_dec_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  cobs_dec_rx_if.sink   rx,
  cobs_dec_res_if.source res
);

  logic    core_valid;
  logic    core_ready;
  result_t core_res;
  result_t out_res;

  cobs_dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .rx_byte   (rx.rx_byte),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  cobs_dec_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (core_valid),
    .in_ready  (core_ready),
    .in_res    (core_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind         = out_res.kind;
  assign res.data_byte    = out_res.data_byte;
  assign res.frame_length = out_res.frame_length;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import cobs_dec_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int REPORT_MAX   = 10;

  logic clk = 1'b0;
  logic rst;

  cobs_dec_rx_if  rx_ch ();
  cobs_dec_res_if res_ch ();

  cobs_stream_decoder uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state as predicted from the accepted byte stream
  logic [7:0]         frame_code;
  logic [7:0]         frame_left;
  logic [COUNT_W-1:0] frame_count;

  result_t     decoded_due[$];
  int unsigned bad_results = 0;
  int unsigned bytes_sent = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_stall_en = 1'b1;
  logic        hold_request = 1'b0;

  task decode_byte(input logic [7:0] b);
    result_t r;
    logic    emit;
    r = '0;
    r.kind = KIND_DATA;
    emit = 1'b1;
    if (frame_count == COUNT_LIMIT && b != DELIM) begin
      // frame full: abort and take this byte as the code of a new frame
      r.kind = KIND_OVERFLOW;
      frame_code = b;
      frame_left = b - 8'd1;
      frame_count = '0;
    end else if (frame_left != 8'd0) begin
      if (b == DELIM) begin
        r.kind = KIND_GARBAGE;
        frame_code = CODE_FULL;
        frame_left = 8'd0;
        frame_count = '0;
      end else begin
        r.data_byte = b;
        frame_left = frame_left - 8'd1;
        frame_count = frame_count + 1'b1;
      end
    end else if (b == DELIM) begin
      if (frame_code == CODE_FULL && frame_count == '0) begin
        r.kind = KIND_EMPTY;
      end else begin
        r.kind = KIND_END;
        r.frame_length = LEN_W'(frame_count);
      end
      frame_code = CODE_FULL;
      frame_left = 8'd0;
      frame_count = '0;
    end else begin
      // new block: a restored zero unless the previous block was full
      emit = (frame_code != CODE_FULL);
      if (emit) frame_count = frame_count + 1'b1;
      frame_code = b;
      frame_left = b - 8'd1;
    end
    if (emit) decoded_due.push_back(r);
  endtask

  task automatic flag_result(input string what, input result_t want);
    bad_results++;
    if (bad_results <= REPORT_MAX) begin
      $display("%s: expected kind=%0d data=%02h len=%0d, got kind=%0d data=%02h len=%0d",
               what, want.kind, want.data_byte, want.frame_length,
               res_ch.kind, res_ch.data_byte, res_ch.frame_length);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      frame_code = CODE_FULL;
      frame_left = 8'd0;
      frame_count = '0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (decoded_due.size() == 0) begin
          flag_result("result with nothing due", '0);
        end else begin
          want = decoded_due.pop_front();
          if (res_ch.kind !== want.kind || res_ch.data_byte !== want.data_byte ||
              res_ch.frame_length !== want.frame_length) begin
            flag_result("mismatch", want);
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) decode_byte(rx_ch.rx_byte);
    end
  end

  initial begin : result_sink
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request <= 1'b0;
      end else begin
        res_ch.ready <= !(sink_stall_en && $urandom_range(99) < 16);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (src_idle_en && $urandom_range(99) < 16) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_block(input logic [7:0] code);
    send_byte(code);
    repeat (int'(code) - 1) send_byte(rand_nonzero());
  endtask

  task automatic send_frame();
    int unsigned roll;
    logic [7:0]  code;
    repeat ($urandom_range(1, 4)) begin
      roll = $urandom_range(99);
      if (roll < 2) code = CODE_FULL;
      else if (roll < 15) code = 8'h01;
      else if (roll < 85) code = 8'($urandom_range(2, 8));
      else if (roll < 97) code = 8'($urandom_range(9, 60));
      else code = 8'hFE;
      send_block(code);
    end
    send_byte(DELIM);
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (decoded_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] seq [21];
    seq = '{
      8'h00,                      // delimiter straight after reset
      8'h01, 8'h00,               // lone code byte, zero length
      8'h01, 8'h01, 8'h01, 8'h00, // two restored zeros
      8'h03, 8'h01, 8'hFF, 8'h00, // smallest and largest data
      8'h02, 8'hAA, 8'h02, 8'h55, 8'h00,
      8'h00,                      // delimiter after a finished frame
      8'h04, 8'h11, 8'h00,        // zero inside a block
      8'h00                       // delimiter after an abort
    };
    foreach (seq[i]) send_byte(seq[i]);
    wait_idle();
  endtask

  task automatic test_full_block();
    // no restored zero after a full block, then a full block closing the frame
    send_block(CODE_FULL);
    send_block(8'h05);
    send_byte(DELIM);
    send_block(CODE_FULL);
    send_byte(DELIM);
    wait_idle();
  endtask

  task automatic test_frame_limits();
    src_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    // 8 full blocks plus 15 bytes end exactly at the count limit
    repeat (8) send_block(CODE_FULL);
    send_block(8'h10);
    send_byte(DELIM);
    // limit reached inside a block, next nonzero byte aborts and starts a frame
    repeat (8) send_block(CODE_FULL);
    send_byte(8'h20);
    repeat (15) send_byte(rand_nonzero());
    send_block(8'h03);
    send_byte(DELIM);
    // zero at the limit inside a block
    repeat (8) send_block(CODE_FULL);
    send_byte(8'h20);
    repeat (15) send_byte(rand_nonzero());
    send_byte(DELIM);
    // limit at a block boundary, overflow byte becomes a lone code byte
    repeat (8) send_block(CODE_FULL);
    send_block(8'h10);
    send_byte(8'h01);
    send_byte(DELIM);
    wait_idle();
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_request <= 1'b1;
    repeat (8) send_frame();
    wait_idle();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned goal;
    int unsigned roll;
    logic [7:0]  code;
    goal = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_frame();
      end else if (roll < 88) begin
        // block cut short by a delimiter
        code = 8'($urandom_range(2, 20));
        send_byte(code);
        repeat ($urandom_range(0, int'(code) - 2)) send_byte(rand_nonzero());
        send_byte(DELIM);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_idle();
  endtask

  initial begin
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    rst <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_block();
    test_frame_limits();
    test_backpressure();
    test_random_stream();

    if (bad_results == 0 && decoded_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
